@@ hw/rtl/pal_pkg.sv @@
// ============================================================================
// pal_pkg: shared types and constants for the positional array list
// Field widths, operation and status codes, cell commands, controller states.
// ============================================================================
package pal_pkg;

    localparam int OP_W          = 3;
    localparam int POS_W         = 7;
    localparam int FIELD_W       = 32;
    localparam int STATUS_W      = 2;
    localparam int COUNT_W       = 8;

    localparam int DEPTH_DEF         = 128;
    localparam int KEY_WIDTH_DEF     = 32;
    localparam int PAYLOAD_WIDTH_DEF = 32;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND     = 3'd0,
        OP_INSERT     = 3'd1,
        OP_REMOVE_KEY = 3'd2,
        OP_REMOVE_POS = 3'd3,
        OP_READ       = 3'd4,
        OP_CLEAR      = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_REJECT    = 2'd1,
        STATUS_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_REMOVE,
        CMD_LOAD,
        CMD_SHIFT
    } cell_cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_REMOVE,
        S_FINISH
    } state_t;

endpackage

@@ hw/rtl/pal_if.sv @@
// ============================================================================
// pal_if: request and response channels of the positional array list
// Valid/ready channels; a transaction completes when valid and ready are high.
// ============================================================================
interface pal_req_if;
    logic                        valid;
    logic                        ready;
    logic [pal_pkg::OP_W-1:0]    op;
    logic [pal_pkg::POS_W-1:0]   position;
    logic [pal_pkg::FIELD_W-1:0] entry_key;
    logic [pal_pkg::FIELD_W-1:0] entry_payload;

    modport source (output valid, output op, output position, output entry_key,
                    output entry_payload, input ready);
    modport sink   (input valid, input op, input position, input entry_key,
                    input entry_payload, output ready);
endinterface

interface pal_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [pal_pkg::STATUS_W-1:0] status;
    logic [pal_pkg::COUNT_W-1:0]  count;
    logic [pal_pkg::FIELD_W-1:0]  read_key;
    logic [pal_pkg::FIELD_W-1:0]  read_payload;

    modport source (output valid, output status, output count, output read_key,
                    output read_payload, input ready);
    modport sink   (input valid, input status, input count, input read_key,
                    input read_payload, output ready);
endinterface

@@ hw/rtl/pal_cell.sv @@
// ============================================================================
// pal_cell: one list slot
// Holds one entry and one readout lane stage; shifts with its neighbours.
// ============================================================================
module pal_cell #(
    parameter int KEY_WIDTH     = pal_pkg::KEY_WIDTH_DEF,
    parameter int PAYLOAD_WIDTH = pal_pkg::PAYLOAD_WIDTH_DEF,
    parameter int IDX_W         = pal_pkg::POS_W,
    parameter int INDEX         = 0
) (
    input  logic                     clk,
    input  pal_pkg::cell_cmd_t       cmd,
    input  logic [IDX_W-1:0]         sel_index,
    input  logic [KEY_WIDTH-1:0]     new_key,
    input  logic [PAYLOAD_WIDTH-1:0] new_payload,
    input  logic [KEY_WIDTH-1:0]     lower_key,
    input  logic [PAYLOAD_WIDTH-1:0] lower_payload,
    input  logic [KEY_WIDTH-1:0]     upper_key,
    input  logic [PAYLOAD_WIDTH-1:0] upper_payload,
    input  logic [KEY_WIDTH-1:0]     upper_lane_key,
    input  logic [PAYLOAD_WIDTH-1:0] upper_lane_payload,
    output logic [KEY_WIDTH-1:0]     key,
    output logic [PAYLOAD_WIDTH-1:0] payload,
    output logic [KEY_WIDTH-1:0]     lane_key,
    output logic [PAYLOAD_WIDTH-1:0] lane_payload
);

    localparam logic [IDX_W-1:0] MY_INDEX = IDX_W'(INDEX);

    logic [KEY_WIDTH-1:0]     key_reg,      key_next;
    logic [PAYLOAD_WIDTH-1:0] payload_reg,  payload_next;
    logic [KEY_WIDTH-1:0]     lane_key_reg, lane_key_next;
    logic [PAYLOAD_WIDTH-1:0] lane_pay_reg, lane_pay_next;

    always_comb
    begin
        key_next      = key_reg;
        payload_next  = payload_reg;
        lane_key_next = lane_key_reg;
        lane_pay_next = lane_pay_reg;
        case (cmd)
            pal_pkg::CMD_INSERT:
            begin
                if (MY_INDEX > sel_index)
                begin
                    key_next     = lower_key;
                    payload_next = lower_payload;
                end
                else if (MY_INDEX == sel_index)
                begin
                    key_next     = new_key;
                    payload_next = new_payload;
                end
            end
            pal_pkg::CMD_REMOVE:
            begin
                if (MY_INDEX >= sel_index)
                begin
                    key_next     = upper_key;
                    payload_next = upper_payload;
                end
            end
            pal_pkg::CMD_LOAD:
            begin
                lane_key_next = key_reg;
                lane_pay_next = payload_reg;
            end
            pal_pkg::CMD_SHIFT:
            begin
                lane_key_next = upper_lane_key;
                lane_pay_next = upper_lane_payload;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        payload_reg  <= payload_next;
        lane_key_reg <= lane_key_next;
        lane_pay_reg <= lane_pay_next;
    end

    assign key          = key_reg;
    assign payload      = payload_reg;
    assign lane_key     = lane_key_reg;
    assign lane_payload = lane_pay_reg;

endmodule

@@ hw/rtl/pal_ctrl.sv @@
// ============================================================================
// pal_ctrl: sequencer of the positional array list
// Decodes transactions, drives the cell row, scans the lane, owns the count.
// ============================================================================
module pal_ctrl #(
    parameter int DEPTH         = pal_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH     = pal_pkg::KEY_WIDTH_DEF,
    parameter int PAYLOAD_WIDTH = pal_pkg::PAYLOAD_WIDTH_DEF,
    parameter int CNT_W         = $clog2(DEPTH + 1),
    parameter int IDX_W         = (CNT_W > pal_pkg::POS_W) ? CNT_W : pal_pkg::POS_W
) (
    input  logic                     clk,
    input  logic                     rst_n,
    pal_req_if.sink                  req,
    pal_rsp_if.source                rsp,
    input  logic [KEY_WIDTH-1:0]     head_key,
    input  logic [PAYLOAD_WIDTH-1:0] head_payload,
    output pal_pkg::cell_cmd_t       cmd,
    output logic [IDX_W-1:0]         sel_index,
    output logic [KEY_WIDTH-1:0]     new_key,
    output logic [PAYLOAD_WIDTH-1:0] new_payload
);

    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

    pal_pkg::state_t state_reg, state_next;

    logic [pal_pkg::OP_W-1:0]     op_reg,     op_next;
    logic [pal_pkg::POS_W-1:0]    pos_reg,    pos_next;
    logic [KEY_WIDTH-1:0]         key_reg,    key_next;
    logic [PAYLOAD_WIDTH-1:0]     pay_reg,    pay_next;
    logic [CNT_W-1:0]             count_reg,  count_next;
    logic [CNT_W-1:0]             scan_reg,   scan_next;
    logic [pal_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [pal_pkg::FIELD_W-1:0]  rkey_reg,   rkey_next;
    logic [pal_pkg::FIELD_W-1:0]  rpay_reg,   rpay_next;

    logic                         ovalid_reg,  ovalid_next;
    logic [pal_pkg::STATUS_W-1:0] ostatus_reg, ostatus_next;
    logic [pal_pkg::COUNT_W-1:0]  ocount_reg,  ocount_next;
    logic [pal_pkg::FIELD_W-1:0]  okey_reg,    okey_next;
    logic [pal_pkg::FIELD_W-1:0]  opay_reg,    opay_next;

    logic             accept;
    logic             out_free;
    logic             is_full;
    logic [IDX_W-1:0] pos_ext;
    logic [IDX_W-1:0] cnt_ext;
    logic [IDX_W-1:0] scan_ext;
    logic [CNT_W-1:0] scan_plus;
    logic             key_hit;

    assign accept    = req.valid && req.ready;
    assign out_free  = !ovalid_reg || rsp.ready;
    assign is_full   = (count_reg == FULL);
    assign pos_ext   = IDX_W'(pos_reg);
    assign cnt_ext   = IDX_W'(count_reg);
    assign scan_ext  = IDX_W'(scan_reg);
    assign scan_plus = scan_reg + ONE;
    assign key_hit   = (head_key == key_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pal_pkg::S_IDLE:
            begin
                if (accept)
                    state_next = pal_pkg::S_EXEC;
            end
            pal_pkg::S_EXEC:
            begin
                case (pal_pkg::op_t'(op_reg))
                    pal_pkg::OP_READ:
                        state_next = (pos_ext < cnt_ext) ? pal_pkg::S_SCAN
                                                          : pal_pkg::S_FINISH;
                    pal_pkg::OP_REMOVE_KEY:
                        state_next = (count_reg != '0) ? pal_pkg::S_SCAN
                                                        : pal_pkg::S_FINISH;
                    default:
                        state_next = pal_pkg::S_FINISH;
                endcase
            end
            pal_pkg::S_SCAN:
            begin
                if (pal_pkg::op_t'(op_reg) == pal_pkg::OP_READ)
                begin
                    if (scan_ext == pos_ext)
                        state_next = pal_pkg::S_FINISH;
                end
                else if (key_hit)
                    state_next = pal_pkg::S_REMOVE;
                else if (scan_plus == count_reg)
                    state_next = pal_pkg::S_FINISH;
            end
            pal_pkg::S_REMOVE:
                state_next = pal_pkg::S_FINISH;
            pal_pkg::S_FINISH:
            begin
                if (out_free)
                    state_next = pal_pkg::S_IDLE;
            end
            default:
                state_next = pal_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = pal_pkg::CMD_HOLD;
        sel_index    = pos_ext;
        op_next      = op_reg;
        pos_next     = pos_reg;
        key_next     = key_reg;
        pay_next     = pay_reg;
        count_next   = count_reg;
        scan_next    = scan_reg;
        status_next  = status_reg;
        rkey_next    = rkey_reg;
        rpay_next    = rpay_reg;
        ovalid_next  = ovalid_reg && !rsp.ready;
        ostatus_next = ostatus_reg;
        ocount_next  = ocount_reg;
        okey_next    = okey_reg;
        opay_next    = opay_reg;
        case (state_reg)
            pal_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = req.op;
                    pos_next    = req.position;
                    key_next    = KEY_WIDTH'(req.entry_key);
                    pay_next    = PAYLOAD_WIDTH'(req.entry_payload);
                    status_next = pal_pkg::STATUS_DONE;
                    rkey_next   = '0;
                    rpay_next   = '0;
                    scan_next   = '0;
                end
            end
            pal_pkg::S_EXEC:
            begin
                case (pal_pkg::op_t'(op_reg))
                    pal_pkg::OP_APPEND:
                    begin
                        sel_index = cnt_ext;
                        if (is_full)
                            status_next = pal_pkg::STATUS_REJECT;
                        else
                        begin
                            cmd        = pal_pkg::CMD_INSERT;
                            count_next = count_reg + ONE;
                        end
                    end
                    pal_pkg::OP_INSERT:
                    begin
                        if (is_full || pos_ext > cnt_ext)
                            status_next = pal_pkg::STATUS_REJECT;
                        else
                        begin
                            cmd        = pal_pkg::CMD_INSERT;
                            count_next = count_reg + ONE;
                        end
                    end
                    pal_pkg::OP_REMOVE_POS:
                    begin
                        if (pos_ext >= cnt_ext)
                            status_next = pal_pkg::STATUS_REJECT;
                        else
                        begin
                            cmd        = pal_pkg::CMD_REMOVE;
                            count_next = count_reg - ONE;
                        end
                    end
                    pal_pkg::OP_READ:
                    begin
                        if (pos_ext >= cnt_ext)
                            status_next = pal_pkg::STATUS_REJECT;
                        else
                            cmd = pal_pkg::CMD_LOAD;
                    end
                    pal_pkg::OP_REMOVE_KEY:
                    begin
                        if (count_reg == '0)
                            status_next = pal_pkg::STATUS_NOT_FOUND;
                        else
                            cmd = pal_pkg::CMD_LOAD;
                    end
                    pal_pkg::OP_CLEAR:
                        count_next = '0;
                    default:
                    begin
                    end
                endcase
            end
            pal_pkg::S_SCAN:
            begin
                if (pal_pkg::op_t'(op_reg) == pal_pkg::OP_READ)
                begin
                    if (scan_ext == pos_ext)
                    begin
                        rkey_next = pal_pkg::FIELD_W'(head_key);
                        rpay_next = pal_pkg::FIELD_W'(head_payload);
                    end
                    else
                    begin
                        cmd       = pal_pkg::CMD_SHIFT;
                        scan_next = scan_plus;
                    end
                end
                else if (!key_hit)
                begin
                    if (scan_plus == count_reg)
                        status_next = pal_pkg::STATUS_NOT_FOUND;
                    else
                    begin
                        cmd       = pal_pkg::CMD_SHIFT;
                        scan_next = scan_plus;
                    end
                end
            end
            pal_pkg::S_REMOVE:
            begin
                sel_index  = scan_ext;
                cmd        = pal_pkg::CMD_REMOVE;
                count_next = count_reg - ONE;
            end
            pal_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    ovalid_next  = 1'b1;
                    ostatus_next = status_reg;
                    ocount_next  = pal_pkg::COUNT_W'(count_reg);
                    okey_next    = rkey_reg;
                    opay_next    = rpay_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= pal_pkg::S_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        pos_reg     <= pos_next;
        key_reg     <= key_next;
        pay_reg     <= pay_next;
        scan_reg    <= scan_next;
        status_reg  <= status_next;
        rkey_reg    <= rkey_next;
        rpay_reg    <= rpay_next;
        ostatus_reg <= ostatus_next;
        ocount_reg  <= ocount_next;
        okey_reg    <= okey_next;
        opay_reg    <= opay_next;
    end

    assign req.ready        = (state_reg == pal_pkg::S_IDLE);
    assign rsp.valid        = ovalid_reg;
    assign rsp.status       = ostatus_reg;
    assign rsp.count        = ocount_reg;
    assign rsp.read_key     = okey_reg;
    assign rsp.read_payload = opay_reg;
    assign new_key          = key_reg;
    assign new_payload      = pay_reg;

endmodule

@@ hw/rtl/positional_array_list.sv @@
// ============================================================================
// positional_array_list: bounded ordered list of key/payload entries
// Row of slot cells under a sequencer; insert and remove shift the cells in parallel.
// ============================================================================
// Usage:
//   req carries one operation per transaction: append, insert at position,
//   remove by key, remove at position, read at position, clear. rsp returns
//   one transaction per request with status, entry count and read data.
//   req.ready is high only while the sequencer is idle: one request at a time.
//   Each request steps the sequencer from idle through exec to finish;
//   a read in range at position p adds a lane scan up to p; remove by key
//   adds a lane scan up to the first match and then a remove step, or a
//   scan up to the last entry when no key matches.
//   Reads and key searches stream the entries through a readout lane that
//   moves one cell towards the head each cycle; that lane sets the latency.
//   Reset clears the state, the count and the output valid flag; entry contents are
//   undefined until written and need no clearing pass.
//   A stalled rsp holds its transaction in the output register; a finished
//   operation waits until that register frees before the next request.
// ============================================================================
module positional_array_list #(
    parameter int DEPTH         = pal_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH     = pal_pkg::KEY_WIDTH_DEF,
    parameter int PAYLOAD_WIDTH = pal_pkg::PAYLOAD_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    pal_req_if.sink   req,
    pal_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (CNT_W > pal_pkg::POS_W) ? CNT_W : pal_pkg::POS_W;

    pal_pkg::cell_cmd_t       cmd;
    logic [IDX_W-1:0]         sel_index;
    logic [KEY_WIDTH-1:0]     new_key;
    logic [PAYLOAD_WIDTH-1:0] new_payload;

    logic [KEY_WIDTH-1:0]     ent_key  [DEPTH];
    logic [PAYLOAD_WIDTH-1:0] ent_pay  [DEPTH];
    logic [KEY_WIDTH-1:0]     lane_key [DEPTH];
    logic [PAYLOAD_WIDTH-1:0] lane_pay [DEPTH];

    pal_ctrl #(
        .DEPTH         (DEPTH),
        .KEY_WIDTH     (KEY_WIDTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
        .CNT_W         (CNT_W),
        .IDX_W         (IDX_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .rsp          (rsp),
        .head_key     (lane_key[0]),
        .head_payload (lane_pay[0]),
        .cmd          (cmd),
        .sel_index    (sel_index),
        .new_key      (new_key),
        .new_payload  (new_payload)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [KEY_WIDTH-1:0]     lo_key;
        logic [PAYLOAD_WIDTH-1:0] lo_pay;
        logic [KEY_WIDTH-1:0]     up_key;
        logic [PAYLOAD_WIDTH-1:0] up_pay;
        logic [KEY_WIDTH-1:0]     up_lane_key;
        logic [PAYLOAD_WIDTH-1:0] up_lane_pay;

        if (i == 0)
        begin : g_head
            assign lo_key = ent_key[i];
            assign lo_pay = ent_pay[i];
        end
        else
        begin : g_body
            assign lo_key = ent_key[i-1];
            assign lo_pay = ent_pay[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign up_key      = '0;
            assign up_pay      = '0;
            assign up_lane_key = '0;
            assign up_lane_pay = '0;
        end
        else
        begin : g_next
            assign up_key      = ent_key[i+1];
            assign up_pay      = ent_pay[i+1];
            assign up_lane_key = lane_key[i+1];
            assign up_lane_pay = lane_pay[i+1];
        end

        pal_cell #(
            .KEY_WIDTH     (KEY_WIDTH),
            .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
            .IDX_W         (IDX_W),
            .INDEX         (i)
        ) u_cell (
            .clk                (clk),
            .cmd                (cmd),
            .sel_index          (sel_index),
            .new_key            (new_key),
            .new_payload        (new_payload),
            .lower_key          (lo_key),
            .lower_payload      (lo_pay),
            .upper_key          (up_key),
            .upper_payload      (up_pay),
            .upper_lane_key     (up_lane_key),
            .upper_lane_payload (up_lane_pay),
            .key                (ent_key[i]),
            .payload            (ent_pay[i]),
            .lane_key           (lane_key[i]),
            .lane_payload       (lane_pay[i])
        );
    end

endmodule
